### src/dcma_pkg.sv
// ----------------------------------------------------------------------------
// dcma_pkg
// Shared types and fixed widths for the dual-channel moving average.
// ----------------------------------------------------------------------------
`default_nettype none

package dcma_pkg;

    // port widths fixed by the interface
    localparam int SAMPLE_IN_W = 12;
    localparam int AVG_W       = 12;

    // divider status seen by the sequencer
    typedef struct packed {
        logic busy;
        logic done;
    } t_div_sts;

    typedef enum logic [6:0] {
        ST_IDLE       = 7'b0000001,
        ST_UPD        = 7'b0000010,
        ST_SOIL_GO    = 7'b0000100,
        ST_SOIL_WAIT  = 7'b0001000,
        ST_WATER_GO   = 7'b0010000,
        ST_WATER_WAIT = 7'b0100000,
        ST_HOLD       = 7'b1000000
    } t_state;

endpackage

`default_nettype wire

### src/dual_channel_moving_average.sv
// ----------------------------------------------------------------------------
// dual_channel_moving_average
// Boxcar mean of two ADC channels over the last WINDOW samples.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (i_in_valid / o_in_stall) carries one soil and one water
//   sample per beat. Output channel (o_out_valid / i_out_stall) returns one
//   beat per input beat: the truncated mean of each channel over the samples
//   held so far (count of samples until the ring first wraps, WINDOW after).
//   Both channels keep a running sum; the oldest entry is read from the ring
//   memory and replaced in the accept cycle. One restoring divider, one
//   quotient bit per cycle, is shared by the two channels in turn.
//   Running sums are SUM_W = SAMPLE_BITS + clog2(WINDOW+1) bits wide. One
//   beat is in flight at a time; o_in_stall stays high until the result is
//   loaded into the output register, so the next beat is taken only after
//   that load.
//   A result waiting under i_out_stall holds its payload; a new input beat
//   is still taken and runs until its own result needs the output register.
//   Synchronous reset clears the sums, write position and full flag, and
//   drops o_out_valid. No clearing pass is needed: old entries mask to zero.
// ----------------------------------------------------------------------------
`default_nettype none

module dual_channel_moving_average #(
    parameter int WINDOW      = 10,
    parameter int SAMPLE_BITS = 12
) (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    input  wire logic                             i_in_valid,
    output logic                                  o_in_stall,
    input  wire logic [dcma_pkg::SAMPLE_IN_W-1:0] i_soil_sample,
    input  wire logic [dcma_pkg::SAMPLE_IN_W-1:0] i_water_sample,
    output logic                                  o_out_valid,
    input  wire logic                             i_out_stall,
    output logic      [dcma_pkg::AVG_W-1:0]       o_soil_average,
    output logic      [dcma_pkg::AVG_W-1:0]       o_water_average
);
    import dcma_pkg::*;

    localparam int POS_W = (WINDOW > 1) ? $clog2(WINDOW) : 1;
    localparam int CNT_W = $clog2(WINDOW + 1);
    localparam int SUM_W = SAMPLE_BITS + CNT_W;
    localparam int QX_W  = (SUM_W > AVG_W) ? SUM_W : AVG_W;

    t_state r_state, n_state;

    logic [SAMPLE_BITS-1:0] soil_mem  [WINDOW];
    logic [SAMPLE_BITS-1:0] water_mem [WINDOW];

    logic [SAMPLE_BITS-1:0] r_new_soil, r_new_water;
    logic [SAMPLE_BITS-1:0] r_old_soil, r_old_water;
    logic [SUM_W-1:0]       r_sum_soil, r_sum_water;
    logic [POS_W-1:0]       r_pos;
    logic                   r_full;
    logic [CNT_W-1:0]       r_cnt;
    logic [AVG_W-1:0]       r_soil_q;
    logic                   r_out_valid;
    logic [AVG_W-1:0]       r_soil_avg, r_water_avg;

    logic                   in_acc;
    logic                   wrap;
    logic [SAMPLE_BITS-1:0] old_soil, old_water;
    logic                   div_start;
    logic [SUM_W-1:0]       div_dvd;
    t_div_sts               div_sts;
    logic [SUM_W-1:0]       div_q;
    logic [QX_W-1:0]        q_ext;
    logic                   out_load;

    assign in_acc   = i_in_valid && (r_state == ST_IDLE);
    assign wrap     = (r_pos == POS_W'(WINDOW - 1));
    // entries not yet written read as zero until the ring first wraps
    assign old_soil  = r_full ? r_old_soil  : '0;
    assign old_water = r_full ? r_old_water : '0;

    assign div_start = (r_state == ST_SOIL_GO) || (r_state == ST_WATER_GO);
    assign div_dvd   = (r_state == ST_WATER_GO) ? r_sum_water : r_sum_soil;
    assign q_ext     = QX_W'(div_q);
    assign out_load  = (r_state == ST_HOLD) && (!r_out_valid || !i_out_stall);

    dcma_div #(
        .SUM_W (SUM_W),
        .CNT_W (CNT_W)
    ) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (div_dvd),
        .i_divisor  (r_cnt),
        .o_sts      (div_sts),
        .o_quotient (div_q)
    );

    // ring memories: old entry read and new one written in the accept cycle
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_old_soil       <= soil_mem[r_pos];
            r_old_water      <= water_mem[r_pos];
            soil_mem[r_pos]  <= SAMPLE_BITS'(i_soil_sample);
            water_mem[r_pos] <= SAMPLE_BITS'(i_water_sample);
            r_new_soil       <= SAMPLE_BITS'(i_soil_sample);
            r_new_water      <= SAMPLE_BITS'(i_water_sample);
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE:       if (i_in_valid) n_state = ST_UPD;
            ST_UPD:        n_state = ST_SOIL_GO;
            ST_SOIL_GO:    n_state = ST_SOIL_WAIT;
            ST_SOIL_WAIT:  if (div_sts.done) n_state = ST_WATER_GO;
            ST_WATER_GO:   n_state = ST_WATER_WAIT;
            ST_WATER_WAIT: if (div_sts.done) n_state = ST_HOLD;
            ST_HOLD:       if (out_load) n_state = ST_IDLE;
            default:       n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_sum_soil  <= '0;
            r_sum_water <= '0;
            r_pos       <= '0;
            r_full      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == ST_UPD) begin
                r_sum_soil  <= r_sum_soil + SUM_W'(r_new_soil) - SUM_W'(old_soil);
                r_sum_water <= r_sum_water + SUM_W'(r_new_water) - SUM_W'(old_water);
                if (wrap) begin
                    r_pos  <= '0;
                    r_full <= 1'b1;
                end else begin
                    r_pos <= r_pos + POS_W'(1);
                end
            end
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && !i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == ST_UPD) begin
            r_cnt <= (r_full || wrap) ? CNT_W'(WINDOW) : CNT_W'(r_pos) + CNT_W'(1);
        end
        if ((r_state == ST_SOIL_WAIT) && div_sts.done) begin
            r_soil_q <= q_ext[AVG_W-1:0];
        end
        if (out_load) begin
            r_soil_avg  <= r_soil_q;
            r_water_avg <= q_ext[AVG_W-1:0];
        end
    end

    assign o_in_stall      = (r_state != ST_IDLE);
    assign o_out_valid     = r_out_valid;
    assign o_soil_average  = r_soil_avg;
    assign o_water_average = r_water_avg;

endmodule

`default_nettype wire

### src/dcma_div.sv
// ----------------------------------------------------------------------------
// dcma_div
// Restoring unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module dcma_div #(
    parameter int SUM_W = 16,
    parameter int CNT_W = 4
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_start,
    input  wire logic [SUM_W-1:0]     i_dividend,
    input  wire logic [CNT_W-1:0]     i_divisor,
    output dcma_pkg::t_div_sts        o_sts,
    output logic      [SUM_W-1:0]     o_quotient
);
    import dcma_pkg::*;

    localparam int STEP_W = $clog2(SUM_W + 1);

    logic              r_busy, r_done;
    logic [STEP_W-1:0] r_step;
    logic [SUM_W-1:0]  r_dvd;
    logic [CNT_W-1:0]  r_dsr;
    logic [CNT_W-1:0]  r_rem;

    logic [CNT_W:0]    rem_sh;
    logic [CNT_W:0]    diff;
    logic              q_bit;

    // shift in next dividend bit, try subtract
    assign rem_sh = {r_rem, r_dvd[SUM_W-1]};
    assign diff   = rem_sh - {1'b0, r_dsr};
    assign q_bit  = ~diff[CNT_W];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_step <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_step <= STEP_W'(SUM_W);
            end else if (r_busy) begin
                r_step <= r_step - STEP_W'(1);
                if (r_step == STEP_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_dvd <= i_dividend;
            r_dsr <= i_divisor;
            r_rem <= '0;
        end else if (r_busy) begin
            r_dvd <= {r_dvd[SUM_W-2:0], q_bit};
            r_rem <= q_bit ? diff[CNT_W-1:0] : rem_sh[CNT_W-1:0];
        end
    end

    assign o_sts.busy = r_busy;
    assign o_sts.done = r_done;
    assign o_quotient = r_dvd;

endmodule

`default_nettype wire

### src/dcma_checker.sv
// ----------------------------------------------------------------------------
// dcma_checker
// Port-level checks for the dual-channel moving average.
// ----------------------------------------------------------------------------
`default_nettype none

module dcma_checker (
    input wire logic                             i_clk,
    input wire logic                             i_rst_n,
    input wire logic                             i_in_valid,
    input wire logic                             o_in_stall,
    input wire logic                             o_out_valid,
    input wire logic                             i_out_stall,
    input wire logic [dcma_pkg::AVG_W-1:0]       o_soil_average,
    input wire logic [dcma_pkg::AVG_W-1:0]       o_water_average
);
    import dcma_pkg::*;

    // a waiting result beat holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=>
            o_out_valid && $stable(o_soil_average) && $stable(o_water_average))
        else $error("output beat changed under stall");

    // one beat in flight: busy right after accept
    a_busy_after_acc: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall |=> o_in_stall)
        else $error("input taken again without processing");

    // a result only appears as the in-flight beat completes
    a_result_from_work: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(o_in_stall) && !o_in_stall)
        else $error("result beat without work");

    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("output valid after reset");

endmodule

bind dual_channel_moving_average dcma_checker u_dcma_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_in_valid      (i_in_valid),
    .o_in_stall      (o_in_stall),
    .o_out_valid     (o_out_valid),
    .i_out_stall     (i_out_stall),
    .o_soil_average  (o_soil_average),
    .o_water_average (o_water_average)
);

`default_nettype wire

### tb/avg_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// avg_checker
// Watches both channels of the dual-channel moving average. Each input beat
// updates a local copy of the two sample rings and queues the expected
// means. Each output beat is compared against the oldest queued pair.
// ----------------------------------------------------------------------------

module avg_checker #(
    parameter int WINDOW = 10
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    input  logic                          i_in_stall,
    input  logic [dcma_pkg::SAMPLE_IN_W-1:0] i_soil_sample,
    input  logic [dcma_pkg::SAMPLE_IN_W-1:0] i_water_sample,
    input  logic                          i_out_valid,
    input  logic                          i_out_stall,
    input  logic [dcma_pkg::AVG_W-1:0]    i_soil_average,
    input  logic [dcma_pkg::AVG_W-1:0]    i_water_average,
    output int                            o_fail_count,
    output int                            o_pending
);

    typedef struct packed {
        logic [dcma_pkg::AVG_W-1:0] soil;
        logic [dcma_pkg::AVG_W-1:0] water;
    } t_avg_pair;

    logic [dcma_pkg::SAMPLE_IN_W-1:0] soil_hist [WINDOW];
    logic [dcma_pkg::SAMPLE_IN_W-1:0] water_hist[WINDOW];
    int unsigned                      wr_pos;
    bit                               wrapped;
    t_avg_pair                        pending_avgs[$];
    t_avg_pair                        due;

    // store one sample pair and return the means over the held entries
    function automatic t_avg_pair boxcar_update(
        logic [dcma_pkg::SAMPLE_IN_W-1:0] soil,
        logic [dcma_pkg::SAMPLE_IN_W-1:0] water
    );
        int unsigned count;
        int unsigned soil_sum;
        int unsigned water_sum;
        t_avg_pair   res;
        soil_hist[wr_pos]  = soil;
        water_hist[wr_pos] = water;
        wr_pos = wr_pos + 1;
        if (wr_pos >= WINDOW) begin
            wr_pos  = 0;
            wrapped = 1'b1;
        end
        count     = wrapped ? WINDOW : wr_pos;
        soil_sum  = 0;
        water_sum = 0;
        for (int k = 0; k < count; k++) begin
            soil_sum  += soil_hist[k];
            water_sum += water_hist[k];
        end
        res.soil  = dcma_pkg::AVG_W'(soil_sum / count);
        res.water = dcma_pkg::AVG_W'(water_sum / count);
        return res;
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < WINDOW; k++) begin
                soil_hist[k]  = '0;
                water_hist[k] = '0;
            end
            wr_pos  = 0;
            wrapped = 1'b0;
            pending_avgs.delete();
        end else begin
            if (i_out_valid && !i_out_stall) begin
                if (pending_avgs.size() == 0) begin
                    $error("result beat with nothing expected: soil %0d water %0d",
                           i_soil_average, i_water_average);
                    o_fail_count++;
                end else begin
                    due = pending_avgs.pop_front();
                    if (i_soil_average !== due.soil) begin
                        $error("soil_average: expected %0d, actual %0d",
                               due.soil, i_soil_average);
                        o_fail_count++;
                    end
                    if (i_water_average !== due.water) begin
                        $error("water_average: expected %0d, actual %0d",
                               due.water, i_water_average);
                        o_fail_count++;
                    end
                end
            end
            if (i_in_valid && !i_in_stall)
                pending_avgs.push_back(boxcar_update(i_soil_sample, i_water_sample));
        end
        o_pending = pending_avgs.size();
    end

endmodule

### tb/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Drives the dual-channel moving average with directed and random sample
// pairs under random input gaps and output stalls; the checker predicts and
// compares, and this module reports the verdict.
// ----------------------------------------------------------------------------

module tb_top;

    localparam int WINDOW       = 10;
    localparam int SAMPLE_BITS  = 12;
    localparam int RANDOM_ITEMS = 1950;
    localparam int IDLE_LIMIT   = 4000;
    localparam int DRAIN_CYCLES = 60;

    logic                             i_clk = 1'b0;
    logic                             i_rst_n;
    logic                             i_in_valid;
    logic                             o_in_stall;
    logic [dcma_pkg::SAMPLE_IN_W-1:0] i_soil_sample;
    logic [dcma_pkg::SAMPLE_IN_W-1:0] i_water_sample;
    logic                             o_out_valid;
    logic                             i_out_stall = 1'b0;
    logic [dcma_pkg::AVG_W-1:0]       o_soil_average;
    logic [dcma_pkg::AVG_W-1:0]       o_water_average;

    int fail_count;
    int pending;
    int idle_cycles;
    int stall_left;
    int stall_pick;
    int burst_left;

    always #1 i_clk = ~i_clk;

    dual_channel_moving_average #(
        .WINDOW      (WINDOW),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_top (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_in_valid),
        .o_in_stall      (o_in_stall),
        .i_soil_sample   (i_soil_sample),
        .i_water_sample  (i_water_sample),
        .o_out_valid     (o_out_valid),
        .i_out_stall     (i_out_stall),
        .o_soil_average  (o_soil_average),
        .o_water_average (o_water_average)
    );

    avg_checker #(
        .WINDOW (WINDOW)
    ) u_avg_check (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_in_valid),
        .i_in_stall      (o_in_stall),
        .i_soil_sample   (i_soil_sample),
        .i_water_sample  (i_water_sample),
        .i_out_valid     (o_out_valid),
        .i_out_stall     (i_out_stall),
        .i_soil_average  (o_soil_average),
        .i_water_average (o_water_average),
        .o_fail_count    (fail_count),
        .o_pending       (pending)
    );

    // output stall: short blips, free-running stretches, rare long holds
    always @(posedge i_clk) begin
        if (stall_left != 0) begin
            stall_left <= stall_left - 1;
        end else begin
            stall_pick = $urandom_range(99);
            if (stall_pick < 40) begin
                i_out_stall <= 1'b0;
                stall_left  <= $urandom_range(30);
            end else if (stall_pick < 48) begin
                i_out_stall <= 1'b0;
                stall_left  <= $urandom_range(600, 200);
            end else if (stall_pick < 94) begin
                i_out_stall <= 1'b1;
                stall_left  <= $urandom_range(4);
            end else begin
                i_out_stall <= 1'b1;
                stall_left  <= $urandom_range(150, 40);
            end
        end
    end

    always @(posedge i_clk) begin
        if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("status: fail");
            $finish;
        end
    end

    function automatic logic [dcma_pkg::SAMPLE_IN_W-1:0] draw_sample();
        int unsigned pick;
        pick = $urandom_range(99);
        if (pick < 55)
            return dcma_pkg::SAMPLE_IN_W'($urandom_range(4095));
        else if (pick < 70)
            return ($urandom_range(1) != 0) ? '1 : '0;
        else if (pick < 85)
            return dcma_pkg::SAMPLE_IN_W'(4095 - $urandom_range(15));
        else
            return dcma_pkg::SAMPLE_IN_W'($urandom_range(15));
    endfunction

    // returns at the rising edge where the beat is taken
    task automatic send_beat(
        input logic [dcma_pkg::SAMPLE_IN_W-1:0] soil,
        input logic [dcma_pkg::SAMPLE_IN_W-1:0] water
    );
        i_in_valid     <= 1'b1;
        i_soil_sample  <= soil;
        i_water_sample <= water;
        do @(negedge i_clk); while (o_in_stall);
        @(posedge i_clk);
    endtask

    task automatic sender_gap();
        int unsigned pick;
        int unsigned gap;
        pick = $urandom_range(99);
        if (burst_left != 0) begin
            burst_left--;
            gap = 0;
        end else if (pick < 3) begin
            burst_left = $urandom_range(60, 20);
            gap = 0;
        end else if (pick < 50) begin
            gap = 0;
        end else if (pick < 85) begin
            gap = $urandom_range(3, 1);
        end else if (pick < 97) begin
            gap = $urandom_range(40, 4);
        end else begin
            gap = $urandom_range(120, 60);
        end
        if (gap != 0) begin
            i_in_valid     <= 1'b0;
            i_soil_sample  <= dcma_pkg::SAMPLE_IN_W'($urandom);
            i_water_sample <= dcma_pkg::SAMPLE_IN_W'($urandom);
            repeat (gap) @(posedge i_clk);
        end
    endtask

    task automatic wait_drained();
        i_in_valid <= 1'b0;
        while (pending != 0) @(negedge i_clk);
        @(posedge i_clk);
    endtask

    initial begin
        logic [dcma_pkg::SAMPLE_IN_W-1:0] soil;
        logic [dcma_pkg::SAMPLE_IN_W-1:0] water;
        int                               run_left;

        i_rst_n        = 1'b0;
        i_in_valid     = 1'b0;
        i_soil_sample  = '0;
        i_water_sample = '0;
        burst_left     = 0;
        run_left       = 0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // first beat divides by one, then fill past the wrap with full scale
        send_beat('1, '0);
        for (int k = 0; k < 11; k++) begin
            send_beat('1, '1);
            sender_gap();
        end
        // swap extremes for half a window
        for (int k = 0; k < 5; k++) begin
            send_beat('0, '1);
            sender_gap();
        end
        // walking ones against walking zeros
        for (int k = 0; k < dcma_pkg::SAMPLE_IN_W; k += 2) begin
            send_beat(dcma_pkg::SAMPLE_IN_W'(1) << k, ~(dcma_pkg::SAMPLE_IN_W'(1) << k));
            sender_gap();
        end
        wait_drained();

        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            // runs of a held pair let the mean settle on the input value
            if (run_left == 0) begin
                soil  = draw_sample();
                water = draw_sample();
                if ($urandom_range(19) == 0)
                    run_left = $urandom_range(15, 5);
            end else begin
                run_left--;
            end
            send_beat(soil, water);
            if (n == RANDOM_ITEMS / 2)
                wait_drained();
            else
                sender_gap();
        end

        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (fail_count == 0 && pending == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
